FILE: rtl/rph_pkg.sv
package rph_pkg;

	localparam int unsigned CFG_DATA_W = 56;
	localparam int unsigned MAX_START_COPIES = 8;
	localparam int unsigned COPY_W = 4;

	localparam logic [1:0] ROLE_HOST = 2'd1;
	localparam logic [1:0] ROLE_CLIENT = 2'd2;

	localparam logic [1:0] RST_ROLE = 2'd0;
	localparam logic [31:0] RST_CONTENT = 32'd0;
	localparam logic [7:0] RST_PROTOCOL = 8'd1;
	localparam logic [15:0] RST_TIMEOUT = 16'd10000;
	localparam logic [15:0] RST_PERIOD = 16'd200;
	localparam logic [15:0] RST_START_WAIT = 16'd500;
	localparam logic [3:0] RST_REPEAT = 4'd3;
	localparam logic [55:0] RST_TERMS = 56'd0;

	typedef enum logic [2:0] {
		CFG_ROLE,
		CFG_CONTENT,
		CFG_PROTOCOL,
		CFG_TIMEOUT,
		CFG_PERIOD,
		CFG_START_WAIT,
		CFG_REPEAT,
		CFG_TERMS
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_FRAME = 2'd1,
		ACT_BEGIN = 2'd2
	} act_t;

	typedef enum logic [1:0] {
		FK_ANNOUNCE = 2'd0,
		FK_JOIN = 2'd1,
		FK_START = 2'd2,
		FK_OTHER = 2'd3
	} fkind_t;

	typedef enum logic [1:0] {
		SEND_NONE = 2'd0,
		SEND_ANNOUNCE = 2'd1,
		SEND_JOIN = 2'd2,
		SEND_START = 2'd3
	} send_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_HOSTING = 3'd1,
		PH_LISTENING = 3'd2,
		PH_AWAIT = 3'd3,
		PH_PAIRED = 3'd4,
		PH_FAILED = 3'd5
	} phase_t;

	typedef struct packed {
		logic [1:0] pairing_role;
		logic [31:0] content_identity;
		logic [7:0] protocol_version;
		logic [15:0] pair_limit_ms;
		logic [15:0] beacon_period_ms;
		logic [15:0] start_wait_ms;
		logic [3:0] start_repeat_count;
		logic [55:0] host_session_terms;
	} cfg_t;

	typedef struct packed {
		act_t action;
		logic radio_ready;
		logic [31:0] random_token;
		fkind_t frame_kind;
		logic payload_whole;
		logic [7:0] frame_protocol;
		logic [31:0] frame_content_id;
		logic [31:0] frame_token;
		logic [47:0] sender_address;
		logic [55:0] frame_terms;
	} evt_t;

	typedef struct packed {
		send_t send_kind;
		logic [47:0] destination_address;
		logic [31:0] send_token;
		phase_t link_status;
		logic acting_as_host;
		logic [55:0] agreed_terms;
		logic last_of_run;
	} res_t;

	// one event's outcome: frame copies to send, then the status beat
	typedef struct packed {
		send_t send_kind;
		logic [COPY_W-1:0] copies;
		logic [47:0] dest;
		logic [31:0] token;
		phase_t status;
		logic host;
		logic [55:0] agreed;
	} run_t;

	function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

endpackage

FILE: rtl/rph_ifs.sv
interface rph_evt_if;
	import rph_pkg::*;
	logic valid;
	logic ready;
	evt_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rph_res_if;
	import rph_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/radio_pairing_handshake.sv
// channel    dir  payload   beat
// events     in   evt_t     one tick, received frame or begin request
// results    out  res_t     one sent frame, or the closing status (last_of_run)
// cfg        in   56 bits   register write by index, no read-back
//
// an event is decided from the input register in the cycle after it is taken, and its
// run loads into the result sequencer once run_free is high, which then drives results
// a run is n frame beats then a status beat (1 to 9 beats), one per cycle unless stalled
// the input register takes the next event while the current run still drains
// reset clears handshake state and loads the register defaults
// a stalled results channel holds the run and backs up into events.ready
module radio_pairing_handshake (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input rph_pkg::cfg_idx_t cfg_index,
	input logic [rph_pkg::CFG_DATA_W-1:0] cfg_data,
	rph_evt_if.sink events,
	rph_res_if.source results
);
	import rph_pkg::*;

	cfg_t cfg_q;
	run_t run;
	logic run_load;
	logic run_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pairing_role <= RST_ROLE;
			cfg_q.content_identity <= RST_CONTENT;
			cfg_q.protocol_version <= RST_PROTOCOL;
			cfg_q.pair_limit_ms <= RST_TIMEOUT;
			cfg_q.beacon_period_ms <= RST_PERIOD;
			cfg_q.start_wait_ms <= RST_START_WAIT;
			cfg_q.start_repeat_count <= RST_REPEAT;
			cfg_q.host_session_terms <= RST_TERMS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROLE: cfg_q.pairing_role <= cfg_data[1:0];
				CFG_CONTENT: cfg_q.content_identity <= cfg_data[31:0];
				CFG_PROTOCOL: cfg_q.protocol_version <= cfg_data[7:0];
				CFG_TIMEOUT: cfg_q.pair_limit_ms <= cfg_data[15:0];
				CFG_PERIOD: cfg_q.beacon_period_ms <= cfg_data[15:0];
				CFG_START_WAIT: cfg_q.start_wait_ms <= cfg_data[15:0];
				CFG_REPEAT: cfg_q.start_repeat_count <= cfg_data[3:0];
				CFG_TERMS: cfg_q.host_session_terms <= cfg_data[55:0];
				default: ;
			endcase
		end
	end

	rph_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.events(events),
		.run_free(run_free),
		.run_load(run_load),
		.run(run)
	);

	rph_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.run_load(run_load),
		.run(run),
		.run_free(run_free),
		.results(results)
	);

`ifndef ASSERT_OFF
	a_run_shows: assert property (@(posedge clk) disable iff (!arst_n)
		run_load |=> results.valid)
		else $error("decided run not presented on results");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		run_load |-> (!results.valid || (results.ready && results.data.last_of_run)))
		else $error("new run loaded over an unfinished one");

	a_frame_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.data.send_kind != SEND_NONE) |->
		(results.data.link_status != PH_IDLE && results.data.link_status != PH_FAILED))
		else $error("frame sent while idle or failed");

	a_terms_paired: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.data.agreed_terms != 56'd0) |->
		(results.data.link_status == PH_PAIRED))
		else $error("terms shown while not paired");
`endif

endmodule

FILE: rtl/rph_core.sv
module rph_core (
	input logic clk,
	input logic arst_n,
	input rph_pkg::cfg_t cfg,
	rph_evt_if.sink events,
	input logic run_free,
	output logic run_load,
	output rph_pkg::run_t run
);
	import rph_pkg::*;

	logic evt_vld_s1;
	evt_t evt_s1;

	phase_t phase_q, phase_d;
	logic [15:0] elapsed_q, elapsed_d;
	logic [15:0] next_ann_q, next_ann_d;
	logic [15:0] wait_until_q, wait_until_d;
	logic [31:0] token_q, token_d;
	logic [47:0] peer_q, peer_d;
	logic [55:0] terms_q, terms_d;
	logic host_q, host_d;

	logic [15:0] elapsed_inc;
	logic refuse;
	logic host_join_ok, client_ann_ok, client_start_ok;
	send_t send_kind;
	logic [COPY_W-1:0] copies;
	logic [COPY_W-1:0] repeat_lim;
	phase_t tick_ph;

	assign run_load = evt_vld_s1 && run_free;
	assign events.ready = !evt_vld_s1 || run_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_vld_s1 <= 1'b0;
		end else if (events.ready) begin
			evt_vld_s1 <= events.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (events.ready && events.valid) begin
			evt_s1 <= events.data;
		end
	end

	always_comb begin
		elapsed_inc = sat_add16(elapsed_q, 16'd1);
		refuse = (cfg.pairing_role != ROLE_HOST && cfg.pairing_role != ROLE_CLIENT)
			|| !evt_s1.radio_ready || cfg.content_identity == 32'd0
			|| cfg.pair_limit_ms == 16'd0;
		host_join_ok = phase_q == PH_HOSTING && evt_s1.frame_kind == FK_JOIN
			&& evt_s1.frame_protocol == cfg.protocol_version
			&& evt_s1.frame_token == token_q
			&& evt_s1.frame_content_id == cfg.content_identity;
		client_ann_ok = phase_q == PH_LISTENING && evt_s1.frame_kind == FK_ANNOUNCE
			&& evt_s1.frame_protocol == cfg.protocol_version
			&& evt_s1.frame_content_id == cfg.content_identity;
		// protocol byte is not checked on START
		client_start_ok = phase_q == PH_AWAIT && evt_s1.frame_kind == FK_START
			&& evt_s1.frame_token == token_q
			&& evt_s1.frame_content_id == cfg.content_identity;
		repeat_lim = (cfg.start_repeat_count > COPY_W'(MAX_START_COPIES))
			? COPY_W'(MAX_START_COPIES) : cfg.start_repeat_count;

		phase_d = phase_q;
		elapsed_d = elapsed_q;
		next_ann_d = next_ann_q;
		wait_until_d = wait_until_q;
		token_d = token_q;
		peer_d = peer_q;
		terms_d = terms_q;
		host_d = host_q;
		send_kind = SEND_NONE;
		copies = '0;
		tick_ph = phase_q;

		unique case (evt_s1.action)
			ACT_BEGIN: begin
				if (refuse) begin
					phase_d = PH_FAILED;
				end else begin
					elapsed_d = 16'd0;
					wait_until_d = 16'd0;
					host_d = cfg.pairing_role == ROLE_HOST;
					if (cfg.pairing_role == ROLE_HOST) begin
						token_d = evt_s1.random_token;
						phase_d = PH_HOSTING;
						send_kind = SEND_ANNOUNCE;
						copies = COPY_W'(1);
						next_ann_d = cfg.beacon_period_ms;
					end else begin
						phase_d = PH_LISTENING;
						next_ann_d = 16'd0;
					end
				end
			end
			ACT_TICK: begin
				if (phase_q == PH_HOSTING) begin
					elapsed_d = elapsed_inc;
					priority if (elapsed_inc >= cfg.pair_limit_ms) begin
						phase_d = PH_FAILED;
					end else if (elapsed_inc >= next_ann_q) begin
						send_kind = SEND_ANNOUNCE;
						copies = COPY_W'(1);
						next_ann_d = sat_add16(elapsed_inc, cfg.beacon_period_ms);
					end
				end else if (phase_q == PH_LISTENING || phase_q == PH_AWAIT) begin
					elapsed_d = elapsed_inc;
					// window over: back to listening, and the timeout applies at once
					if (phase_q == PH_AWAIT && elapsed_inc >= wait_until_q) begin
						tick_ph = PH_LISTENING;
					end
					if (tick_ph == PH_LISTENING && elapsed_inc >= cfg.pair_limit_ms) begin
						tick_ph = PH_FAILED;
					end
					phase_d = tick_ph;
				end
			end
			ACT_FRAME: begin
				if (evt_s1.payload_whole) begin
					priority if (host_join_ok) begin
						peer_d = evt_s1.sender_address;
						terms_d = cfg.host_session_terms;
						phase_d = PH_PAIRED;
						send_kind = SEND_START;
						copies = repeat_lim;
					end else if (client_ann_ok) begin
						peer_d = evt_s1.sender_address;
						token_d = evt_s1.frame_token;
						send_kind = SEND_JOIN;
						copies = COPY_W'(1);
						wait_until_d = sat_add16(elapsed_q, cfg.start_wait_ms);
						phase_d = PH_AWAIT;
					end else if (client_start_ok) begin
						terms_d = evt_s1.frame_terms;
						phase_d = PH_PAIRED;
					end
				end
			end
			default: ;
		endcase

		run.send_kind = send_kind;
		run.copies = copies;
		run.dest = (send_kind == SEND_ANNOUNCE) ? 48'd0 : peer_d;
		run.token = token_d;
		run.status = phase_d;
		run.host = host_d;
		run.agreed = (phase_d == PH_PAIRED) ? terms_d : 56'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			elapsed_q <= '0;
			next_ann_q <= '0;
			wait_until_q <= '0;
			token_q <= '0;
			peer_q <= '0;
			terms_q <= '0;
			host_q <= 1'b0;
		end else if (run_load) begin
			phase_q <= phase_d;
			elapsed_q <= elapsed_d;
			next_ann_q <= next_ann_d;
			wait_until_q <= wait_until_d;
			token_q <= token_d;
			peer_q <= peer_d;
			terms_q <= terms_d;
			host_q <= host_d;
		end
	end

endmodule

FILE: rtl/rph_emit.sv
module rph_emit (
	input logic clk,
	input logic arst_n,
	input logic run_load,
	input rph_pkg::run_t run,
	output logic run_free,
	rph_res_if.source results
);
	import rph_pkg::*;

	logic busy_q;
	logic [COPY_W-1:0] left_q;
	run_t run_q;
	logic status_beat;

	assign status_beat = left_q == '0;
	assign run_free = !busy_q || (results.ready && status_beat);
	assign results.valid = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			left_q <= '0;
		end else if (run_load) begin
			busy_q <= 1'b1;
			left_q <= run.copies;
		end else if (busy_q && results.ready) begin
			if (status_beat) begin
				busy_q <= 1'b0;
			end else begin
				left_q <= left_q - COPY_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_load) begin
			run_q <= run;
		end
	end

	// frame copies first, the status beat closes the run
	always_comb begin
		results.data.link_status = run_q.status;
		results.data.acting_as_host = run_q.host;
		results.data.agreed_terms = run_q.agreed;
		if (status_beat) begin
			results.data.send_kind = SEND_NONE;
			results.data.destination_address = 48'd0;
			results.data.send_token = 32'd0;
			results.data.last_of_run = 1'b1;
		end else begin
			results.data.send_kind = run_q.send_kind;
			results.data.destination_address = run_q.dest;
			results.data.send_token = run_q.token;
			results.data.last_of_run = 1'b0;
		end
	end

endmodule
